[rtl/wcenv_pkg.sv]
// Shared constants, types and helpers for the waveform column envelope block.
`timescale 1ns / 1ps
package wcenv_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int MAX_COLUMNS  = 4096;

  localparam int WL_W   = 16;
  localparam int HH_W   = 12;
  localparam int COL_W  = 12;
  localparam int TOP_W  = 13;
  localparam int HGT_W  = 14;

  localparam int ABS_W  = SAMPLE_WIDTH + 1;
  localparam int SUM_W  = WL_W + SAMPLE_WIDTH - 1;
  localparam int TOT_W  = SUM_W + 1;
  localparam int PROD_W = HH_W + TOT_W;
  localparam int LOW_W  = SAMPLE_WIDTH - 2;
  localparam int DVD_W  = PROD_W - LOW_W;
  localparam int STEP_W = $clog2(DVD_W);
  localparam int CNT_W  = $clog2(MAX_COLUMNS);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE   = 2'd2;

  typedef struct packed {
    logic [SUM_W-1:0] lsum;
    logic [TOT_W-1:0] tsum;
    logic [CNT_W-1:0] col;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [ABS_W-1:0] abs_sample(input logic [SAMPLE_WIDTH-1:0] s);
    logic [ABS_W-1:0] ext;
    ext = {s[SAMPLE_WIDTH-1], s};
    return s[SAMPLE_WIDTH-1] ? (~ext + 1'b1) : ext;
  endfunction

endpackage

[rtl/wcenv_front.sv]
// Front end: takes sample words, accumulates window sums, queues window-end jobs.
`timescale 1ns / 1ps
module wcenv_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [wcenv_pkg::SAMPLE_WIDTH-1:0] left_sample,
  input  logic signed [wcenv_pkg::SAMPLE_WIDTH-1:0] right_sample,
  input  logic                                   first_of_clip,
  input  logic [wcenv_pkg::WL_W-1:0]             window_length,
  input  logic                                   stereo_mode,
  input  logic                                   q_full,
  output logic                                   push,
  output wcenv_pkg::job_t                        job
);
  import wcenv_pkg::*;

  logic [SUM_W-1:0] lsum, lsum_next, base_l;
  logic [TOT_W-1:0] tsum, tsum_next, base_t;
  logic [WL_W-1:0]  fill, fill_next, base_f;
  logic [CNT_W-1:0] col, col_base;
  logic [ABS_W-1:0] la, ra;
  logic             accept, win_end;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    la        = abs_sample(left_sample);
    ra        = stereo_mode ? abs_sample(right_sample) : la;
    base_l    = first_of_clip ? '0 : lsum;
    base_t    = first_of_clip ? '0 : tsum;
    base_f    = first_of_clip ? '0 : fill;
    col_base  = first_of_clip ? '0 : col;
    lsum_next = base_l + SUM_W'(la);
    tsum_next = base_t + TOT_W'(la) + TOT_W'(ra);
    fill_next = base_f + 1'b1;
    win_end   = fill_next >= window_length;
  end

  assign push     = accept && win_end;
  assign job.lsum = lsum_next;
  assign job.tsum = tsum_next;
  assign job.col  = col_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      lsum <= '0;
      tsum <= '0;
      fill <= '0;
      col  <= '0;
    end else if (accept) begin
      if (win_end) begin
        lsum <= '0;
        tsum <= '0;
        fill <= '0;
        col  <= (col_base < CNT_W'(MAX_COLUMNS - 1)) ? col_base + 1'b1 : col_base;
      end else begin
        lsum <= lsum_next;
        tsum <= tsum_next;
        fill <= fill_next;
        col  <= col_base;
      end
    end
  end

endmodule

[rtl/wcenv_fifo.sv]
// Two-entry job queue between front end and back end.
`timescale 1ns / 1ps
module wcenv_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wcenv_pkg::job_t    din,
  input  logic               pop,
  output wcenv_pkg::job_t    dout,
  output wcenv_pkg::q_stat_t stat
);
  import wcenv_pkg::*;

  job_t       mem [2];
  logic       wp, rp;
  logic [1:0] count;

  assign dout       = mem[rp];
  assign stat.full  = count == 2'd2;
  assign stat.empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/wcenv_back.sv]
// Back end: scales window sums, divides by window length serially, holds the result word.
`timescale 1ns / 1ps
module wcenv_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  input  wcenv_pkg::job_t                     job_in,
  output logic                                pop,
  input  logic [wcenv_pkg::WL_W-1:0]          window_length,
  input  logic [wcenv_pkg::HH_W-1:0]          half_height,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wcenv_pkg::COL_W-1:0]         column,
  output logic signed [wcenv_pkg::TOP_W-1:0]  bar_top,
  output logic [wcenv_pkg::HGT_W-1:0]         bar_height
);
  import wcenv_pkg::*;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_MUL_L = 3'd1;
  localparam logic [2:0] B_MUL_T = 3'd2;
  localparam logic [2:0] B_DIV   = 3'd3;
  localparam logic [2:0] B_OUT   = 3'd4;

  logic [2:0]        state;
  job_t              job;
  logic [TOT_W-1:0]  mul_a;
  logic [PROD_W-1:0] prod;
  logic [DVD_W-1:0]  dvd_l, dvd_t;
  logic [WL_W-1:0]   rem_l, rem_t, rem_l_next, rem_t_next;
  logic [WL_W:0]     r2_l, r2_t;
  logic              ge_l, ge_t, lo_l, ceil_l, slot_free;
  logic [STEP_W-1:0] step;

  assign pop       = (state == B_IDLE) && !q_empty;
  assign slot_free = !out_valid || !out_stall;
  assign mul_a     = (state == B_MUL_L) ? TOT_W'(job.lsum) : job.tsum;
  assign prod      = PROD_W'(half_height) * PROD_W'(mul_a);

  always_comb begin
    r2_l       = {rem_l, dvd_l[DVD_W-1]};
    r2_t       = {rem_t, dvd_t[DVD_W-1]};
    ge_l       = r2_l >= {1'b0, window_length};
    ge_t       = r2_t >= {1'b0, window_length};
    rem_l_next = ge_l ? WL_W'(r2_l - {1'b0, window_length}) : r2_l[WL_W-1:0];
    rem_t_next = ge_t ? WL_W'(r2_t - {1'b0, window_length}) : r2_t[WL_W-1:0];
    ceil_l     = lo_l || (rem_l != '0);
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) job <= job_in;
      end
      B_MUL_L: begin
        dvd_l <= prod[PROD_W-1:LOW_W];
        lo_l  <= |prod[LOW_W-1:0];
        rem_l <= '0;
      end
      B_MUL_T: begin
        dvd_t <= prod[PROD_W-1:LOW_W];
        rem_t <= '0;
      end
      B_DIV: begin
        dvd_l <= {dvd_l[DVD_W-2:0], ge_l};
        dvd_t <= {dvd_t[DVD_W-2:0], ge_t};
        rem_l <= rem_l_next;
        rem_t <= rem_t_next;
      end
      B_OUT: begin
        if (slot_free) begin
          column     <= COL_W'(job.col);
          bar_top    <= TOP_W'(half_height) - TOP_W'(dvd_l) - TOP_W'(ceil_l);
          bar_height <= dvd_t[HGT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == B_OUT && slot_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!q_empty) state <= B_MUL_L;
        end
        B_MUL_L: state <= B_MUL_T;
        B_MUL_T: begin
          step  <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(DVD_W - 1)) state <= B_OUT;
        end
        B_OUT: begin
          if (slot_free) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[rtl/waveform_column_envelope.sv]
// Top level of the waveform column envelope: config registers, front end, queue, back end.
`timescale 1ns / 1ps
// One stereo sample word is taken per cycle while the two-entry job queue has room; the
// word that closes a window queues a job; the back end takes it through one dispatch state,
// two multiply states, a 30-step restoring divider running both quotients side by side and
// one output state. Windows that outlast a job stream at one word per cycle while out_stall
// is low; shorter ones stall the input once the queue fills. Each result word gives the
// column (saturating), the bar top and the bar height, floored to whole pixels. A
// window_length write of zero stores one; config may be written only while the block is idle.
module waveform_column_envelope (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [wcenv_pkg::SAMPLE_WIDTH-1:0] left_sample,
  input  logic signed [wcenv_pkg::SAMPLE_WIDTH-1:0] right_sample,
  input  logic                                     first_of_clip,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [wcenv_pkg::COL_W-1:0]              column,
  output logic signed [wcenv_pkg::TOP_W-1:0]       bar_top,
  output logic [wcenv_pkg::HGT_W-1:0]              bar_height,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [wcenv_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [wcenv_pkg::WL_W-1:0]               cfg_data
);
  import wcenv_pkg::*;

  logic [WL_W-1:0] window_length;
  logic [HH_W-1:0] half_height;
  logic            stereo_mode;
  logic            push, pop;
  job_t            job_in, job_out;
  q_stat_t         q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WL_W'(1);
      half_height   <= HH_W'(64);
      stereo_mode   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= (cfg_data == '0) ? WL_W'(1) : cfg_data;
        REG_HALF_HEIGHT:   half_height   <= cfg_data[HH_W-1:0];
        REG_STEREO_MODE:   stereo_mode   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  wcenv_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .left_sample   (left_sample),
    .right_sample  (right_sample),
    .first_of_clip (first_of_clip),
    .window_length (window_length),
    .stereo_mode   (stereo_mode),
    .q_full        (q_stat.full),
    .push          (push),
    .job           (job_in)
  );

  wcenv_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (job_in),
    .pop  (pop),
    .dout (job_out),
    .stat (q_stat)
  );

  wcenv_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_stat.empty),
    .job_in        (job_out),
    .pop           (pop),
    .window_length (window_length),
    .half_height   (half_height),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .column        (column),
    .bar_top       (bar_top),
    .bar_height    (bar_height)
  );

  a_out_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result word valid right after reset");

  a_q_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("job queue reports full and empty at once");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> !pop)
    else $error("job popped from an empty queue");

endmodule
